// ===== hw/rtl/text_frame_buffer_cursor_defines.svh =====
// ----------------------------------------------------------------------------
// text frame buffer cursor assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef TEXT_FRAME_BUFFER_CURSOR_DEFINES_SVH
`define TEXT_FRAME_BUFFER_CURSOR_DEFINES_SVH

// same-cycle implication
`define TFBC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tfbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tfbc_pkg
// geometry, field widths, control codes and shared types of the frame buffer
// ----------------------------------------------------------------------------
package tfbc_pkg;

  localparam int LINE_LEN  = 16;
  localparam int NUM_LINES = 3;
  localparam int CELLS     = LINE_LEN * NUM_LINES;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CUR_W     = $clog2(CELLS + 1);

  localparam int FUNC_W = 1;
  localparam int CHAR_W = 8;
  localparam int RADDR_W = 6;
  localparam int CPOS_W = 6;

  localparam logic [FUNC_W-1:0] FUNC_PUT  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_FF    = 8'd12;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 8'h20;

  // cursor update result for one put transfer
  typedef struct packed {
    logic [CUR_W-1:0]  cur_nxt;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              clr;
  } tfbc_upd_t;

endpackage

// ===== hw/rtl/tfbc_if.sv =====
// ----------------------------------------------------------------------------
// tfbc channel interfaces
// valid/ready channels for put/read requests and for results
// ----------------------------------------------------------------------------
interface tfbc_in_if;
  import tfbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CHAR_W-1:0]  char_code;
  logic [RADDR_W-1:0] read_addr;

  modport source (output valid, func, char_code, read_addr, input ready);
  modport sink   (input valid, func, char_code, read_addr, output ready);
endinterface

interface tfbc_out_if;
  import tfbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] read_data;
  logic [CPOS_W-1:0] cursor_pos;
  logic [CHAR_W-1:0] echoed_char;

  modport source (output valid, read_data, cursor_pos, echoed_char, input ready);
  modport sink   (input valid, read_data, cursor_pos, echoed_char, output ready);
endinterface

// ===== hw/rtl/tfbc_ram.sv =====
// ----------------------------------------------------------------------------
// tfbc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tfbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tfbc_cursor.sv =====
// ----------------------------------------------------------------------------
// tfbc_cursor
// decodes one put byte against the current cursor into a cursor update,
// a cell write and a buffer clear
// ----------------------------------------------------------------------------
module tfbc_cursor (
  input  logic [tfbc_pkg::CUR_W-1:0]  cursor,
  input  logic [tfbc_pkg::CHAR_W-1:0] char_code,
  output tfbc_pkg::tfbc_upd_t         upd
);
  import tfbc_pkg::*;

  logic [CUR_W-1:0] line_start;
  logic [CUR_W:0]   next_start;
  logic             in_range;
  logic [CUR_W-1:0] wpos;

  // start of the line holding the cursor
  always_comb begin
    line_start = '0;
    for (int k = 0; k < NUM_LINES; k++) begin
      if (cursor >= CUR_W'(k * LINE_LEN)) begin
        line_start = CUR_W'(k * LINE_LEN);
      end
    end
  end

  assign next_start = {1'b0, line_start} + (CUR_W + 1)'(LINE_LEN);
  assign in_range   = (cursor < CUR_W'(CELLS));
  assign wpos       = in_range ? cursor : '0;

  always_comb begin
    upd.cur_nxt = cursor;
    upd.we      = 1'b0;
    upd.waddr   = ADDR_W'(wpos);
    upd.clr     = 1'b0;
    case (char_code)
      CODE_BS: begin
        if (cursor != '0) begin
          upd.cur_nxt = cursor - CUR_W'(1);
        end
      end
      CODE_FF: begin
        upd.cur_nxt = '0;
        upd.clr     = 1'b1;
      end
      CODE_NL: begin
        if (in_range) begin
          upd.cur_nxt = (next_start >= (CUR_W + 1)'(CELLS)) ? '0 : CUR_W'(next_start);
        end
      end
      CODE_CR: begin
        if (in_range) begin
          upd.cur_nxt = line_start;
        end
      end
      default: begin
        upd.we      = 1'b1;
        upd.cur_nxt = wpos + CUR_W'(1);
      end
    endcase
  end

endmodule

// ===== hw/rtl/text_frame_buffer_cursor.sv =====
// ----------------------------------------------------------------------------
// text_frame_buffer_cursor
// small terminal-style character frame buffer with a write cursor
// ----------------------------------------------------------------------------
// The block holds NUM_LINES x LINE_LEN character cells (3 x 16 by default) in
// one synchronous RAM and keeps a write cursor in a register. A put transfer
// (func 0) prints a byte or acts on backspace, form feed, newline or carriage
// return; a read transfer (func 1) returns one cell for the display refresher.
// Every transfer gives exactly one result, in order. Sustained rate is one
// transfer per cycle while out_ch takes results; a result passes through
// the lookup stage (waiting on the cell RAM read) and the output register.
// Cells are tracked by one valid flag each: reset and form feed drop all the
// flags at once, and a cell without its flag reads back as a space, so
// there is no clearing sweep and the block is ready right out of reset.
// ----------------------------------------------------------------------------
module text_frame_buffer_cursor (
  input  logic       clk,
  input  logic       rst_n,
  tfbc_in_if.sink    in_ch,
  tfbc_out_if.source out_ch
);
  import tfbc_pkg::*;
  `include "text_frame_buffer_cursor_defines.svh"

  // cursor and per-cell valid flags
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [CELLS-1:0] vld_r, vld_nxt;

  // lookup stage: waits on the ram read
  logic              pend_r;
  logic              pend_hit_r;   // in-range read
  logic              pend_vld_r;   // cell flag sampled at transfer
  logic [CUR_W-1:0]  pend_cur_r;
  logic [CHAR_W-1:0] pend_code_r;

  // output register
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_data_r;
  logic [CUR_W-1:0]  out_cur_r;
  logic [CHAR_W-1:0] out_code_r;

  logic              in_xfer;
  logic              pend_adv;
  logic              is_put;
  logic              rd_hit;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CHAR_W-1:0] cell_data;
  tfbc_upd_t         upd;

  // lookup moves into the output register when it is free or draining
  assign pend_adv     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !pend_r || pend_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign is_put       = (in_ch.func == FUNC_PUT);
  assign rd_hit       = !is_put && (in_ch.read_addr < RADDR_W'(CELLS));
  assign raddr        = ADDR_W'(in_ch.read_addr);

  tfbc_cursor u_cursor (
    .cursor    (cursor_r),
    .char_code (in_ch.char_code),
    .upd       (upd)
  );

  tfbc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (in_xfer && is_put && upd.we),
    .waddr (upd.waddr),
    .wdata (in_ch.char_code),
    .re    (in_xfer && rd_hit),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // cursor and flag updates on a put transfer
  always_comb begin
    cursor_nxt = cursor_r;
    vld_nxt    = vld_r;
    if (in_xfer && is_put) begin
      cursor_nxt = upd.cur_nxt;
      if (upd.clr) begin
        vld_nxt = '0;
      end else if (upd.we) begin
        vld_nxt[upd.waddr] = 1'b1;
      end
    end
  end

  // a never-written or cleared cell shows a space
  assign cell_data = pend_hit_r ? (pend_vld_r ? ram_rdata : CODE_SPACE) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      vld_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cursor_r <= cursor_nxt;
      vld_r    <= vld_nxt;
      if (pend_r && pend_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        pend_r <= 1'b1;
      end else if (pend_adv) begin
        pend_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_hit_r  <= rd_hit;
      pend_vld_r  <= vld_r[raddr];
      pend_cur_r  <= cursor_nxt;
      pend_code_r <= in_ch.char_code;
    end
    if (pend_r && pend_adv) begin
      out_data_r <= cell_data;
      out_cur_r  <= pend_cur_r;
      out_code_r <= pend_code_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_data_r;
  assign out_ch.cursor_pos  = CPOS_W'(out_cur_r);
  assign out_ch.echoed_char = out_code_r;

  `TFBC_ASSERT_NOW(a_cursor_bound, 1'b1, cursor_r <= CUR_W'(CELLS), "cursor beyond end position")
  `TFBC_ASSERT_NEXT(a_ff_home, in_xfer && is_put && in_ch.char_code == CODE_FF, cursor_r == '0 && vld_r == '0, "form feed did not home and clear")
  `TFBC_ASSERT_NEXT(a_pend_hold, pend_r && !pend_adv, pend_r && $stable(pend_cur_r), "lookup lost while output stalled")
  `TFBC_ASSERT_NEXT(a_read_keeps, in_xfer && !is_put, $stable(cursor_r) && $stable(vld_r), "read transfer changed state")

endmodule
